/* rtl/scp_pkg.sv */
// shared widths, register map and reset values for the sprite camera projection
package scp_pkg;

    localparam int POS_W    = 24;
    localparam int VEC_W    = 18;
    localparam int RES_W    = 13;
    localparam int DEPTH_W  = 24;
    localparam int COL_W    = 16;
    localparam int SIZE_W   = 15;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    localparam logic [RES_W-1:0] WIDTH_RESET  = RES_W'(640);
    localparam logic [RES_W-1:0] HEIGHT_RESET = RES_W'(480);

    typedef enum logic [2:0] {
        REG_PLAYER_X,
        REG_PLAYER_Y,
        REG_DIR_X,
        REG_DIR_Y,
        REG_PLANE_X,
        REG_PLANE_Y,
        REG_SCREEN_WIDTH,
        REG_SCREEN_HEIGHT
    } scp_reg_t;

endpackage

/* rtl/scp_if.sv */
// valid/ready channels for sprite positions and projection results
interface scp_in_if import scp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  sprite_x;
    logic [POS_W-1:0]  sprite_y;

    modport source (output valid, output sprite_x, output sprite_y, input ready);
    modport sink   (input valid, input sprite_x, input sprite_y, output ready);
endinterface

interface scp_out_if import scp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [DEPTH_W-1:0]  depth;
    logic signed [COL_W-1:0]    center_column;
    logic [SIZE_W-1:0]          sprite_size;
    logic [SIZE_W-1:0]          first_row;
    logic [SIZE_W-1:0]          last_row;
    logic [SIZE_W-1:0]          first_column;
    logic signed [COL_W-1:0]    last_column;
    logic                       invalid;

    modport source (output valid, output depth, output center_column, output sprite_size,
                    output first_row, output last_row, output first_column,
                    output last_column, output invalid, input ready);
    modport sink   (input valid, input depth, input center_column, input sprite_size,
                    input first_row, input last_row, input first_column,
                    input last_column, input invalid, output ready);
endinterface

/* rtl/scp_div.sv */
// pipelined unsigned restoring divider, one quotient bit per stage, with an overflow flag
module scp_div import scp_pkg::*; #(
    parameter int NW = 60,
    parameter int DW = 37,
    parameter int QW = 30,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic          ovf,
    output logic [SW-1:0] side_out
);

    localparam int CW = (NW > DW) ? NW : DW;

    logic          v_reg    [0:QW];
    logic [DW-1:0] rem_reg  [0:QW];
    logic [QW-1:0] lo_reg   [0:QW];
    logic [QW-1:0] quo_reg  [0:QW];
    logic          ovf_reg  [0:QW];
    logic [DW-1:0] den_reg  [0:QW];
    logic [SW-1:0] side_reg [0:QW];

    logic ovf_in;

    // quotient at or above 2^QW when the top part of num already reaches den
    assign ovf_in = CW'(num >> QW) >= CW'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= DW'(num >> QW);
            lo_reg[0]   <= num[QW-1:0];
            quo_reg[0]  <= '0;
            ovf_reg[0]  <= ovf_in;
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [DW:0] trial;
        logic        ge;

        assign trial = {rem_reg[k], lo_reg[k][QW-1]};
        assign ge    = trial >= {1'b0, den_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? DW'(trial - {1'b0, den_reg[k]}) : DW'(trial);
                lo_reg[k+1]   <= {lo_reg[k][QW-2:0], 1'b0};
                quo_reg[k+1]  <= {quo_reg[k][QW-2:0], ge};
                ovf_reg[k+1]  <= ovf_reg[k];
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign quo       = quo_reg[QW];
    assign ovf       = ovf_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

/* rtl/sprite_camera_projection.sv */
// top level: sprite projection pipeline with its apb register file
//
// Each sprite item passes a 54-register pipeline and one item is taken every
// cycle while the output side does not stall. The depth is dominated by three
// pipelined restoring dividers that each resolve one quotient bit per stage:
// depth (ny * 2^16 / det) and center column run side by side over 31 stages,
// the sprite size (height * 2^16 / |depth|) over 16 more. The whole pipeline
// holds while the output register is full and not taken, so a stall loses
// nothing. Registers are written over apb at byte address 4*index and should
// only be changed while no item is in flight.
module sprite_camera_projection import scp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,
    scp_in_if.sink             sprite_in,
    scp_out_if.source          proj_out
);

    // ---------------- register file ----------------
    logic [POS_W-1:0]        player_x_reg, player_y_reg;
    logic signed [VEC_W-1:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [RES_W-1:0]        width_reg, height_reg;
    scp_reg_t                reg_sel;
    logic                    wr_en;

    assign pready  = 1'b1;
    assign reg_sel = scp_reg_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_x_reg <= '0;
            player_y_reg <= '0;
            dir_x_reg    <= '0;
            dir_y_reg    <= '0;
            plane_x_reg  <= '0;
            plane_y_reg  <= '0;
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_PLAYER_X:      player_x_reg <= pwdata[POS_W-1:0];
                REG_PLAYER_Y:      player_y_reg <= pwdata[POS_W-1:0];
                REG_DIR_X:         dir_x_reg    <= pwdata[VEC_W-1:0];
                REG_DIR_Y:         dir_y_reg    <= pwdata[VEC_W-1:0];
                REG_PLANE_X:       plane_x_reg  <= pwdata[VEC_W-1:0];
                REG_PLANE_Y:       plane_y_reg  <= pwdata[VEC_W-1:0];
                REG_SCREEN_WIDTH:  width_reg    <= pwdata[RES_W-1:0];
                REG_SCREEN_HEIGHT: height_reg   <= pwdata[RES_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_PLAYER_X:      prdata = APB_DW'(player_x_reg);
            REG_PLAYER_Y:      prdata = APB_DW'(player_y_reg);
            REG_DIR_X:         prdata = APB_DW'(unsigned'(dir_x_reg));
            REG_DIR_Y:         prdata = APB_DW'(unsigned'(dir_y_reg));
            REG_PLANE_X:       prdata = APB_DW'(unsigned'(plane_x_reg));
            REG_PLANE_Y:       prdata = APB_DW'(unsigned'(plane_y_reg));
            REG_SCREEN_WIDTH:  prdata = APB_DW'(width_reg);
            REG_SCREEN_HEIGHT: prdata = APB_DW'(height_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // every stage advances together whenever the output register can move
    logic en;
    logic out_v_reg;

    assign en              = !out_v_reg || proj_out.ready;
    assign sprite_in.ready = en;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= sprite_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // stage 1: sprite offset from player, determinant products
    logic signed [24:0] rx_reg, ry_reg;
    logic signed [35:0] pa_reg, pb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg <= $signed({1'b0, sprite_in.sprite_x}) - $signed({1'b0, player_x_reg});
            ry_reg <= $signed({1'b0, sprite_in.sprite_y}) - $signed({1'b0, player_y_reg});
            pa_reg <= plane_x_reg * dir_y_reg;
            pb_reg <= dir_x_reg * plane_y_reg;
        end
    end

    // stage 2: determinant and the four transform products
    logic signed [36:0] det2_reg;
    logic signed [42:0] m1_reg, m2_reg, m3_reg, m4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det2_reg <= 37'(pa_reg) - 37'(pb_reg);
            m1_reg   <= dir_y_reg * rx_reg;
            m2_reg   <= dir_x_reg * ry_reg;
            m3_reg   <= plane_x_reg * ry_reg;
            m4_reg   <= plane_y_reg * rx_reg;
        end
    end

    // stage 3: ny and nx + ny
    logic signed [36:0] det3_reg;
    logic signed [43:0] ny3_reg;
    logic signed [44:0] sum3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det3_reg <= det2_reg;
            ny3_reg  <= 44'(m3_reg) - 44'(m4_reg);
            sum3_reg <= 45'(m1_reg) - 45'(m2_reg) + 45'(m3_reg) - 45'(m4_reg);
        end
    end

    // stage 4: column numerator (w/2) * (nx + ny)
    logic signed [36:0] det4_reg;
    logic signed [43:0] ny4_reg;
    logic signed [57:0] cprod4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det4_reg   <= det3_reg;
            ny4_reg    <= ny3_reg;
            cprod4_reg <= $signed({1'b0, width_reg[RES_W-1:1]}) * sum3_reg;
        end
    end

    // stage 5: magnitudes and quotient signs for both dividers
    logic [59:0] dnum5_reg;
    logic [36:0] dden5_reg;
    logic [57:0] cnum5_reg;
    logic [43:0] cden5_reg;
    logic        dneg5_reg, cneg5_reg, detz5_reg;
    logic [43:0] ny_mag;

    assign ny_mag = ny4_reg[43] ? 44'(-ny4_reg) : 44'(ny4_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dnum5_reg <= {ny_mag, 16'b0};
            dden5_reg <= det4_reg[36] ? 37'(-det4_reg) : 37'(det4_reg);
            dneg5_reg <= ny4_reg[43] ^ det4_reg[36];
            detz5_reg <= det4_reg == '0;
            cnum5_reg <= cprod4_reg[57] ? 58'(-cprod4_reg) : 58'(cprod4_reg);
            cden5_reg <= ny_mag;
            cneg5_reg <= cprod4_reg[57] ^ ny4_reg[43];
        end
    end

    // depth and column dividers, 30 quotient bits plus an overflow flag
    logic        dv, cv, dovf, covf;
    logic [29:0] dq, cq;
    logic [1:0]  dside;
    logic        cside;

    scp_div #(.NW(60), .DW(37), .QW(30), .SW(2)) u_div_depth (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v5_reg),
        .num(dnum5_reg), .den(dden5_reg), .side_in({dneg5_reg, detz5_reg}),
        .out_valid(dv), .quo(dq), .ovf(dovf), .side_out(dside)
    );

    scp_div #(.NW(58), .DW(44), .QW(30), .SW(1)) u_div_col (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v5_reg),
        .num(cnum5_reg), .den(cden5_reg), .side_in(cneg5_reg),
        .out_valid(cv), .quo(cq), .ovf(covf), .side_out(cside)
    );

    // stage 6: signed, saturated depth and column; |depth| clamped for the size divide
    logic                      d_big, c_big, d_zero;
    logic signed [DEPTH_W-1:0] depth_n;
    logic signed [COL_W-1:0]   col_n;
    logic [29:0]               dmag_n;

    assign d_big  = dovf || (dq[29:23] != '0);
    assign c_big  = covf || (cq[29:15] != '0);
    assign d_zero = !dovf && (dq == '0);
    assign dmag_n = dovf ? '1 : dq;

    always_comb
    begin
        if (dside[1])
        begin
            depth_n = d_big ? {1'b1, {(DEPTH_W-1){1'b0}}} : -$signed(dq[23:0]);
        end
        else
        begin
            depth_n = d_big ? {1'b0, {(DEPTH_W-1){1'b1}}} : $signed(dq[23:0]);
        end
        if (cside)
        begin
            col_n = c_big ? {1'b1, {(COL_W-1){1'b0}}} : -$signed(cq[15:0]);
        end
        else
        begin
            col_n = c_big ? {1'b0, {(COL_W-1){1'b1}}} : $signed(cq[15:0]);
        end
    end

    logic signed [DEPTH_W-1:0] depth6_reg;
    logic signed [COL_W-1:0]   col6_reg;
    logic [29:0]               dmag6_reg;
    logic                      inv6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg <= dv && cv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            depth6_reg <= depth_n;
            col6_reg   <= col_n;
            dmag6_reg  <= dmag_n;
            inv6_reg   <= dside[0] || d_zero;
        end
    end

    // size divider: height * 2^16 / |depth|, saturating at 15 bits
    logic                      sv, sovf, s_inv;
    logic [SIZE_W-1:0]         sq;
    logic signed [DEPTH_W-1:0] s_depth;
    logic signed [COL_W-1:0]   s_col;

    scp_div #(.NW(29), .DW(30), .QW(15), .SW(41)) u_div_size (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v6_reg),
        .num({height_reg, 16'b0}), .den(dmag6_reg),
        .side_in({depth6_reg, col6_reg, inv6_reg}),
        .out_valid(sv), .quo(sq), .ovf(sovf), .side_out({s_depth, s_col, s_inv})
    );

    // output stage: row and column bounds clamped to the screen
    logic [SIZE_W-1:0]      size_n;
    logic [13:0]            half;
    logic [11:0]            hh;
    logic signed [15:0]     r0s;
    logic [14:0]            r1u;
    logic signed [16:0]     c0s, c1s;
    logic [SIZE_W-1:0]      r0_n, r1_n, c0_n;
    logic signed [COL_W-1:0] c1_n;

    assign size_n = sovf ? '1 : sq;
    assign half   = size_n[SIZE_W-1:1];
    assign hh     = height_reg[RES_W-1:1];
    assign r0s    = $signed({4'b0, hh}) - $signed({2'b0, half});
    assign r1u    = {3'b0, hh} + {1'b0, half};
    assign c0s    = 17'(s_col) - $signed({3'b0, half});
    assign c1s    = 17'(s_col) + $signed({3'b0, half});

    always_comb
    begin
        r0_n = r0s[15] ? '0 : r0s[14:0];
        if ({1'b0, r1u} >= {3'b0, height_reg})
        begin
            // empty screen gives a bound of minus one, held at zero
            r1_n = (height_reg == '0) ? '0 : 15'(height_reg - 1'b1);
        end
        else
        begin
            r1_n = r1u;
        end
        c0_n = c0s[16] ? '0 : c0s[14:0];
        if (c1s >= $signed({4'b0, width_reg}))
        begin
            c1_n = $signed(16'({3'b0, width_reg} - 16'd1));
        end
        else
        begin
            c1_n = c1s[15:0];
        end
    end

    logic signed [DEPTH_W-1:0] depth_reg;
    logic signed [COL_W-1:0]   col_reg, last_col_reg;
    logic [SIZE_W-1:0]         size_reg, first_row_reg, last_row_reg, first_col_reg;
    logic                      inv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= sv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (s_inv)
            begin
                // degenerate projection: flag only, all other fields zero
                depth_reg     <= '0;
                col_reg       <= '0;
                size_reg      <= '0;
                first_row_reg <= '0;
                last_row_reg  <= '0;
                first_col_reg <= '0;
                last_col_reg  <= '0;
                inv_reg       <= 1'b1;
            end
            else
            begin
                depth_reg     <= s_depth;
                col_reg       <= s_col;
                size_reg      <= size_n;
                first_row_reg <= r0_n;
                last_row_reg  <= r1_n;
                first_col_reg <= c0_n;
                last_col_reg  <= c1_n;
                inv_reg       <= 1'b0;
            end
        end
    end

    assign proj_out.valid         = out_v_reg;
    assign proj_out.depth         = depth_reg;
    assign proj_out.center_column = col_reg;
    assign proj_out.sprite_size   = size_reg;
    assign proj_out.first_row     = first_row_reg;
    assign proj_out.last_row      = last_row_reg;
    assign proj_out.first_column  = first_col_reg;
    assign proj_out.last_column   = last_col_reg;
    assign proj_out.invalid       = inv_reg;

endmodule
